// ===== hdl/rwpf_pkg.sv =====
// rwpf_pkg: shared types, codes and sizes for the register write policy filter
// used by rwpf_ctrl, rwpf_dp and register_write_policy_filter; no dependencies
`default_nettype none
package rwpf_pkg;

  localparam int ADDR_BITS = 8;
  localparam int DEPTH     = 1 << ADDR_BITS;
  localparam int DATA_BITS = 32;

  typedef logic [ADDR_BITS-1:0] slot_t;
  typedef logic [DATA_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_LOAD   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STS_STORED    = 3'd0,
    STS_CLAMPED   = 3'd1,
    STS_REFUSED   = 3'd2,
    STS_LOADED    = 3'd3,
    STS_DUPLICATE = 3'd4,
    STS_READ      = 3'd5
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic  readonly;
    logic  range_correct;
    logic  sgn;
    word_t lower;
    word_t upper;
  } rule_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  typedef struct packed {
    logic req_none;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/register_write_policy_filter.sv =====
// register_write_policy_filter: one request beat in, one result beat out per request
// each request and its registered store reads are captured, then the result beat register is
// loaded once the output can take a beat
// no new request is taken until the last result beat is registered: store read, then update
// an unused request type is taken while idle and gives no result beat
// synchronous active-low reset clears the control state and all valid and rule-present flags
`default_nettype none
module register_write_policy_filter
  import rwpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_address,
  input  logic [31:0] in_value,
  input  logic        in_attr_readonly,
  input  logic        in_attr_range_correct,
  input  logic        in_attr_signed,
  input  logic [31:0] in_attr_lower,
  input  logic [31:0] in_attr_upper,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rwpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rwpf_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_req_type           (in_req_type),
    .in_address            (in_address),
    .in_value              (in_value),
    .in_attr_readonly      (in_attr_readonly),
    .in_attr_range_correct (in_attr_range_correct),
    .in_attr_signed        (in_attr_signed),
    .in_attr_lower         (in_attr_lower),
    .in_attr_upper         (in_attr_upper),
    .out_status            (out_status),
    .out_data              (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/rwpf_ctrl.sv =====
// rwpf_ctrl: sequencing state machine and result beat valid flag
// depends on rwpf_pkg; drives the command struct of rwpf_dp
`default_nettype none
module rwpf_ctrl
  import rwpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    in_stall    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !sts.req_none) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.execute = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== hdl/rwpf_dp.sv =====
// rwpf_dp: register store, rule store, write policy logic and result beat register
// depends on rwpf_pkg; controlled by rwpf_ctrl through dp_cmd_t
`default_nettype none
module rwpf_dp
  import rwpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_address,
  input  logic [31:0] in_value,
  input  logic        in_attr_readonly,
  input  logic        in_attr_range_correct,
  input  logic        in_attr_signed,
  input  logic [31:0] in_attr_lower,
  input  logic [31:0] in_attr_upper,
  output logic [2:0]  out_status,
  output logic [31:0] out_data
);

  word_t            reg_mem  [DEPTH];
  rule_t            rule_mem [DEPTH];
  logic [DEPTH-1:0] reg_vld_r;
  logic [DEPTH-1:0] present_r;

  slot_t   slot;
  req_t    req_r;
  slot_t   slot_r;
  word_t   value_r;
  rule_t   attr_r;
  word_t   reg_rd_r;
  rule_t   rule_rd_r;
  logic    reg_vld_rd_r;
  logic    present_rd_r;
  status_t out_status_r;
  word_t   out_data_r;

  word_t   cur;
  word_t   new_val;
  status_t status;
  logic    wr_reg;
  logic    wr_rule;

  assign slot         = ADDR_BITS'(in_address);
  assign sts.req_none = (req_t'(in_req_type) == REQ_UNUSED);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r        <= req_t'(in_req_type);
      slot_r       <= slot;
      value_r      <= in_value;
      attr_r       <= '{readonly:      in_attr_readonly,
                        range_correct: in_attr_range_correct,
                        sgn:           in_attr_signed,
                        lower:         in_attr_lower,
                        upper:         in_attr_upper};
      reg_rd_r     <= reg_mem[slot];
      rule_rd_r    <= rule_mem[slot];
      reg_vld_rd_r <= reg_vld_r[slot];
      present_rd_r <= present_r[slot];
    end
    if (cmd.execute) begin
      if (wr_reg) begin
        reg_mem[slot_r] <= new_val;
      end
      if (wr_rule) begin
        rule_mem[slot_r] <= attr_r;
      end
      out_status_r <= status;
      out_data_r   <= wr_reg ? new_val : cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_vld_r <= '0;
      present_r <= '0;
    end else if (cmd.execute) begin
      if (wr_reg) begin
        reg_vld_r[slot_r] <= 1'b1;
      end
      if (wr_rule) begin
        present_r[slot_r] <= 1'b1;
      end
    end
  end

  assign cur = reg_vld_rd_r ? reg_rd_r : '0;

  always_comb begin
    new_val = value_r;
    status  = STS_STORED;
    wr_reg  = 1'b0;
    wr_rule = 1'b0;
    case (req_r)
      REQ_WRITE: begin
        if (!present_rd_r) begin
          wr_reg = 1'b1;
        end else if (rule_rd_r.readonly) begin
          status = STS_REFUSED;
        end else begin
          wr_reg = 1'b1;
          if (rule_rd_r.sgn) begin
            if (rule_rd_r.range_correct) begin
              if ($signed(value_r) < $signed(rule_rd_r.lower)) begin
                new_val = rule_rd_r.lower;
                status  = STS_CLAMPED;
              end else if ($signed(rule_rd_r.upper) < $signed(value_r)) begin
                new_val = rule_rd_r.upper;
                status  = STS_CLAMPED;
              end
            end else if (value_r[DATA_BITS-1]) begin
              new_val = value_r | rule_rd_r.lower;
            end else begin
              new_val = value_r & rule_rd_r.upper;
            end
          end else if (rule_rd_r.range_correct) begin
            if (value_r < rule_rd_r.lower) begin
              new_val = rule_rd_r.lower;
              status  = STS_CLAMPED;
            end else if (value_r > rule_rd_r.upper) begin
              new_val = rule_rd_r.upper;
              status  = STS_CLAMPED;
            end
          end else begin
            new_val = value_r & rule_rd_r.upper;
          end
        end
      end
      REQ_READ: status = STS_READ;
      REQ_LOAD: begin
        if (present_rd_r) begin
          status = STS_DUPLICATE;
        end else begin
          wr_rule = 1'b1;
          status  = STS_LOADED;
        end
      end
      default: status = STS_READ;
    endcase
  end

  assign out_status = out_status_r;
  assign out_data   = out_data_r;

endmodule
`default_nettype wire
